// ----- rtl/core/msct_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// msct_pkg: shared types and constants of the countdown timer table
// widths of the beat fields, command codes, queue entry and result layout
// ----------------------------------------------------------------------------
package msct_pkg;

    // table size and derived index width
    localparam int SLOTS = 16;
    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    // beat field widths
    localparam int CMD_W     = 2;
    localparam int SLOT_W    = 6;
    localparam int COUNT_W   = 32;
    localparam int ELAPSED_W = 31;
    localparam int DUE_W     = 31;

    localparam logic [SLOT_W-1:0] SLOT_LIMIT = SLOT_W'(SLOTS);
    localparam logic [IDX_W-1:0]  LAST_IDX   = IDX_W'(SLOTS - 1);

    // prime conversion: values below the limit are microseconds
    localparam logic signed [COUNT_W-1:0] MICRO_LIMIT = -32'sd30;
    localparam int MICRO_DIV = 1000;
    localparam longint unsigned RECIP = 64'h1_0000_0000 / MICRO_DIV;
    localparam int RECIP_W = $clog2(RECIP + 1);
    localparam logic [RECIP_W-1:0] RECIP_C = RECIP_W'(RECIP);
    localparam int PROD_W = COUNT_W + RECIP_W;

    localparam logic [DUE_W-1:0]          NO_DEADLINE = {DUE_W{1'b1}};
    localparam logic signed [COUNT_W-1:0] INACTIVE    = -32'sd1;

    // command queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    typedef enum logic [CMD_W-1:0] {
        OP_INSERT = 2'd0,
        OP_REMOVE = 2'd1,
        OP_PRIME  = 2'd2,
        OP_TICK   = 2'd3
    } t_op;

    typedef enum logic {
        KIND_FIRED   = 1'b0,
        KIND_SUMMARY = 1'b1
    } t_kind;

    typedef enum logic [1:0] {
        B_IDLE,
        B_FIX,
        B_SCAN,
        B_SUM
    } t_back_state;

    typedef struct packed {
        t_op                    op;
        logic                   slot_ok;
        logic [IDX_W-1:0]       idx;
        logic                   micro;
        logic [COUNT_W-1:0]     value;
        logic [ELAPSED_W-1:0]   elapsed;
    } t_cmd_item;

    typedef struct packed {
        t_kind                  kind;
        logic [SLOT_W-1:0]      fired_slot;
        logic [DUE_W-1:0]       next_due;
        logic                   due_valid;
        logic                   last;
    } t_result;

endpackage
`default_nettype wire

// ----- rtl/core/msct_cmd_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// msct_cmd_if: command channel
// valid/ready handshake carrying one timer command beat
// ----------------------------------------------------------------------------
interface msct_cmd_if;
    logic                                   valid;
    logic                                   ready;
    logic [msct_pkg::CMD_W-1:0]             cmd;
    logic [msct_pkg::SLOT_W-1:0]            slot;
    logic signed [msct_pkg::COUNT_W-1:0]    count;
    logic [msct_pkg::ELAPSED_W-1:0]         elapsed;

    modport source (output valid, cmd, slot, count, elapsed, input ready);
    modport sink   (input valid, cmd, slot, count, elapsed, output ready);
endinterface
`default_nettype wire

// ----- rtl/core/msct_res_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// msct_res_if: result channel
// valid/ready handshake carrying one fired or summary beat
// ----------------------------------------------------------------------------
interface msct_res_if;
    logic                           valid;
    logic                           ready;
    logic                           kind;
    logic [msct_pkg::SLOT_W-1:0]    fired_slot;
    logic [msct_pkg::DUE_W-1:0]     next_due;
    logic                           due_valid;
    logic                           last;

    modport source (output valid, kind, fired_slot, next_due, due_valid, last, input ready);
    modport sink   (input valid, kind, fired_slot, next_due, due_valid, last, output ready);
endinterface
`default_nettype wire

// ----- rtl/core/multi_slot_countdown_timer_top.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// multi_slot_countdown_timer_top: table of one-shot millisecond timers
// insert, remove, prime and tick commands in; fired and summary beats out
// ----------------------------------------------------------------------------
// Each command beat produces zero or more fired beats (one per slot that runs
// out on a tick, in ascending slot order) followed by exactly one summary beat
// with last set, giving the least positive remaining count or no deadline.
// An item is taken from the command queue in the idle state, which applies
// insert, remove or a millisecond prime; the table scan then visits one slot
// per cycle, unless a fired beat is held, updating counts on a tick and
// tracking the minimum, and the summary state sends the summary beat. A
// microsecond prime passes through the correction step of the divide by 1000
// before the scan. A fired beat that finds the result register still full
// holds the scan until the sink takes the waiting beat. The two-entry command
// queue accepts new beats while the table is busy.
// ----------------------------------------------------------------------------
module multi_slot_countdown_timer_top (
    input  wire         i_clk,
    input  wire         i_rst_n,
    msct_cmd_if.sink    i_cmd_ch,
    msct_res_if.source  o_res_ch
);

    // classifier to queue
    logic                   push_valid;
    logic                   push_ready;
    msct_pkg::t_cmd_item    push_item;

    // queue to table sequencer
    logic                   pop_valid;
    logic                   pop_ready;
    msct_pkg::t_cmd_item    pop_item;

    // decode and range check each command beat
    msct_front u_front (
        .i_cmd_ch     (i_cmd_ch),
        .o_push_valid (push_valid),
        .o_push_item  (push_item),
        .i_push_ready (push_ready)
    );

    // lets the front take beats while a scan runs
    msct_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .i_push_item  (push_item),
        .o_push_ready (push_ready),
        .o_pop_valid  (pop_valid),
        .o_pop_item   (pop_item),
        .i_pop_ready  (pop_ready)
    );

    // slot table, scan and registered result beat
    msct_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pop_valid (pop_valid),
        .i_pop_item  (pop_item),
        .o_pop_ready (pop_ready),
        .o_res_ch    (o_res_ch)
    );

endmodule
`default_nettype wire

// ----- rtl/core/msct_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// msct_front: command classifier
// decodes a command beat, range checks the slot, pre-negates microsecond counts
// ----------------------------------------------------------------------------
module msct_front (
    msct_cmd_if.sink                i_cmd_ch,
    output logic                    o_push_valid,
    output msct_pkg::t_cmd_item     o_push_item,
    input  logic                    i_push_ready
);

    assign o_push_valid   = i_cmd_ch.valid;
    assign i_cmd_ch.ready = i_push_ready;

    always_comb begin
        o_push_item.op      = msct_pkg::t_op'(i_cmd_ch.cmd);
        o_push_item.slot_ok = (i_cmd_ch.slot < msct_pkg::SLOT_LIMIT);
        o_push_item.idx     = i_cmd_ch.slot[msct_pkg::IDX_W-1:0];
        o_push_item.micro   = (i_cmd_ch.count < msct_pkg::MICRO_LIMIT);
        // magnitude of a microsecond count, most negative value included
        if (o_push_item.micro) begin
            o_push_item.value = ~i_cmd_ch.count + msct_pkg::COUNT_W'(1);
        end else begin
            o_push_item.value = i_cmd_ch.count;
        end
        o_push_item.elapsed = i_cmd_ch.elapsed;
    end

endmodule
`default_nettype wire

// ----- rtl/core/msct_queue.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// msct_queue: command queue
// small fifo that decouples the classifier from the table sequencer
// ----------------------------------------------------------------------------
module msct_queue (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_push_valid,
    input  msct_pkg::t_cmd_item     i_push_item,
    output logic                    o_push_ready,
    output logic                    o_pop_valid,
    output msct_pkg::t_cmd_item     o_pop_item,
    input  logic                    i_pop_ready
);

    msct_pkg::t_cmd_item                r_mem [msct_pkg::QUEUE_DEPTH];
    logic [msct_pkg::QUEUE_AW-1:0]      r_wr_ptr;
    logic [msct_pkg::QUEUE_AW-1:0]      r_rd_ptr;
    logic [msct_pkg::QUEUE_AW:0]        r_count;
    logic [msct_pkg::QUEUE_AW-1:0]      n_wr_ptr;
    logic [msct_pkg::QUEUE_AW-1:0]      n_rd_ptr;
    logic [msct_pkg::QUEUE_AW:0]        n_count;
    logic                               push;
    logic                               pop;

    assign o_push_ready = (r_count != (msct_pkg::QUEUE_AW + 1)'(msct_pkg::QUEUE_DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_item   = r_mem[r_rd_ptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    always_comb begin
        n_wr_ptr = push ? r_wr_ptr + 1'b1 : r_wr_ptr;
        n_rd_ptr = pop ? r_rd_ptr + 1'b1 : r_rd_ptr;
        n_count  = r_count;
        if (push && !pop) begin
            n_count = r_count + 1'b1;
        end else if (pop && !push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_push_item;
        end
    end

`ifndef SYNTHESIS
    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= (msct_pkg::QUEUE_AW + 1)'(msct_pkg::QUEUE_DEPTH))
        else $error("command queue holds more entries than its depth");
`endif

endmodule
`default_nettype wire

// ----- rtl/core/msct_back.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// msct_back: table sequencer
// applies commands to the slot table, scans it for firings and next deadline
// ----------------------------------------------------------------------------
module msct_back (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_pop_valid,
    input  msct_pkg::t_cmd_item     i_pop_item,
    output logic                    o_pop_ready,
    msct_res_if.source              o_res_ch
);

    msct_pkg::t_back_state                  r_state;
    msct_pkg::t_back_state                  n_state;
    msct_pkg::t_cmd_item                    r_item;
    msct_pkg::t_cmd_item                    n_item;
    logic [msct_pkg::IDX_W-1:0]             r_cnt;
    logic [msct_pkg::IDX_W-1:0]             n_cnt;
    logic [msct_pkg::DUE_W-1:0]             r_min;
    logic [msct_pkg::DUE_W-1:0]             n_min;
    logic [msct_pkg::RECIP_W-1:0]           r_quo;
    logic [msct_pkg::RECIP_W-1:0]           n_quo;
    logic [msct_pkg::SLOTS-1:0]             r_enr;
    logic [msct_pkg::SLOTS-1:0]             n_enr;
    logic signed [msct_pkg::COUNT_W-1:0]    r_rem [msct_pkg::SLOTS];
    logic                                   r_ovalid;
    logic                                   n_ovalid;
    msct_pkg::t_result                      r_out;
    msct_pkg::t_result                      n_out;

    logic                                   wr_en;
    logic [msct_pkg::IDX_W-1:0]             wr_idx;
    logic signed [msct_pkg::COUNT_W-1:0]    wr_data;

    logic                                   out_free;
    logic signed [msct_pkg::COUNT_W-1:0]    rv;
    logic signed [msct_pkg::COUNT_W-1:0]    diff;
    logic signed [msct_pkg::COUNT_W-1:0]    cand;
    logic                                   is_tick;
    logic                                   active;
    logic                                   fire;
    logic                                   cand_ok;
    logic [msct_pkg::PROD_W-1:0]            prod;
    logic [msct_pkg::COUNT_W-1:0]           back_prod;
    logic [msct_pkg::COUNT_W-1:0]           part;
    logic [msct_pkg::RECIP_W-1:0]           quo_fix;
    logic signed [msct_pkg::COUNT_W-1:0]    plain_val;

    assign out_free    = !r_ovalid || o_res_ch.ready;
    assign o_pop_ready = (r_state == msct_pkg::B_IDLE);

    // one slot visit per cycle unless a firing slot waits for the result register
    assign rv      = r_rem[r_cnt];
    assign is_tick = (r_item.op == msct_pkg::OP_TICK);
    assign active  = r_enr[r_cnt] && (rv > 0);
    assign diff    = rv - $signed({1'b0, r_item.elapsed});
    assign fire    = is_tick && active && (diff <= 0);
    assign cand    = is_tick ? diff : rv;
    assign cand_ok = active && !fire;

    // reciprocal estimate, then one correction step
    assign prod      = msct_pkg::PROD_W'(i_pop_item.value) * msct_pkg::PROD_W'(msct_pkg::RECIP_C);
    assign back_prod = msct_pkg::COUNT_W'(r_quo) * msct_pkg::COUNT_W'(msct_pkg::MICRO_DIV);
    assign part      = r_item.value - back_prod;
    assign quo_fix   = (part >= msct_pkg::COUNT_W'(msct_pkg::MICRO_DIV)) ? r_quo + 1'b1 : r_quo;
    assign plain_val = ($signed(i_pop_item.value) <= 0) ? msct_pkg::COUNT_W'(1)
                                                         : $signed(i_pop_item.value);

    always_comb begin
        n_state  = r_state;
        n_item   = r_item;
        n_cnt    = r_cnt;
        n_min    = r_min;
        n_quo    = r_quo;
        n_enr    = r_enr;
        n_ovalid = r_ovalid && !o_res_ch.ready;
        n_out    = r_out;
        wr_en    = 1'b0;
        wr_idx   = r_cnt;
        wr_data  = diff;

        case (r_state)
            msct_pkg::B_IDLE: begin
                if (i_pop_valid) begin
                    n_item  = i_pop_item;
                    n_cnt   = '0;
                    n_min   = msct_pkg::NO_DEADLINE;
                    n_state = msct_pkg::B_SCAN;
                    wr_idx  = i_pop_item.idx;
                    case (i_pop_item.op)
                        msct_pkg::OP_INSERT: begin
                            if (i_pop_item.slot_ok) begin
                                n_enr[i_pop_item.idx] = 1'b1;
                                wr_en   = 1'b1;
                                wr_data = msct_pkg::INACTIVE;
                            end
                        end
                        msct_pkg::OP_REMOVE: begin
                            if (i_pop_item.slot_ok) begin
                                n_enr[i_pop_item.idx] = 1'b0;
                            end
                        end
                        msct_pkg::OP_PRIME: begin
                            if (i_pop_item.micro) begin
                                n_quo   = prod[msct_pkg::PROD_W-1 -: msct_pkg::RECIP_W];
                                n_state = msct_pkg::B_FIX;
                            end else begin
                                wr_en   = i_pop_item.slot_ok;
                                wr_data = plain_val;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            msct_pkg::B_FIX: begin
                wr_en   = r_item.slot_ok;
                wr_idx  = r_item.idx;
                wr_data = (quo_fix == '0) ? msct_pkg::COUNT_W'(1)
                                          : msct_pkg::COUNT_W'(quo_fix);
                n_state = msct_pkg::B_SCAN;
            end
            msct_pkg::B_SCAN: begin
                // a firing slot waits for the result register
                if (!fire || out_free) begin
                    wr_en = is_tick && active;
                    if (fire) begin
                        n_ovalid         = 1'b1;
                        n_out.kind       = msct_pkg::KIND_FIRED;
                        n_out.fired_slot = msct_pkg::SLOT_W'(r_cnt);
                        n_out.next_due   = '0;
                        n_out.due_valid  = 1'b0;
                        n_out.last       = 1'b0;
                    end
                    if (cand_ok && (cand[msct_pkg::DUE_W-1:0] < r_min)) begin
                        n_min = cand[msct_pkg::DUE_W-1:0];
                    end
                    if (r_cnt == msct_pkg::LAST_IDX) begin
                        n_state = msct_pkg::B_SUM;
                    end else begin
                        n_cnt = r_cnt + 1'b1;
                    end
                end
            end
            msct_pkg::B_SUM: begin
                if (out_free) begin
                    n_ovalid         = 1'b1;
                    n_out.kind       = msct_pkg::KIND_SUMMARY;
                    n_out.fired_slot = '0;
                    n_out.due_valid  = (r_min != msct_pkg::NO_DEADLINE);
                    n_out.next_due   = (r_min != msct_pkg::NO_DEADLINE) ? r_min : '0;
                    n_out.last       = 1'b1;
                    n_state          = msct_pkg::B_IDLE;
                end
            end
            default: begin
                n_state = msct_pkg::B_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= msct_pkg::B_IDLE;
            r_enr    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_enr    <= n_enr;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_item <= n_item;
        r_cnt  <= n_cnt;
        r_min  <= n_min;
        r_quo  <= n_quo;
        r_out  <= n_out;
        if (wr_en) begin
            r_rem[wr_idx] <= wr_data;
        end
    end

    assign o_res_ch.valid      = r_ovalid;
    assign o_res_ch.kind       = r_out.kind;
    assign o_res_ch.fired_slot = r_out.fired_slot;
    assign o_res_ch.next_due   = r_out.next_due;
    assign o_res_ch.due_valid  = r_out.due_valid;
    assign o_res_ch.last       = r_out.last;

`ifndef SYNTHESIS
    a_fired_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && r_out.kind == msct_pkg::KIND_FIRED) |-> !r_out.last)
        else $error("fired beat marked as last");
    a_fired_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && r_out.kind == msct_pkg::KIND_FIRED)
            |-> (r_out.fired_slot < msct_pkg::SLOT_LIMIT))
        else $error("fired slot outside the table");
    a_scan_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == msct_pkg::B_SCAN && $past(r_state) != msct_pkg::B_SCAN)
            |-> (r_cnt == '0))
        else $error("scan did not start at slot zero");
    a_fix_after_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == msct_pkg::B_FIX) |-> ($past(r_state) == msct_pkg::B_IDLE))
        else $error("correction step not entered from idle");
`endif

endmodule
`default_nettype wire

// ----- tb/sv/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the countdown timer table
// walks a short table of directed commands, then random command streams in
// four flow-control phases; every fired and summary beat is checked field by
// field against the typed summary of its row or an in-bench model of the slot table
// ----------------------------------------------------------------------------
module tb;
    import msct_pkg::*;

    localparam int HALF_PERIOD  = 6;
    localparam int RESET_CYCLES = 5;
    localparam int PHASE_ITEMS  = 47;    // four phases, about 190 random beats
    localparam int DRAIN_CYCLES = 40;
    localparam int MAX_REPORTS  = 10;

    // one command beat as the bench builds it
    typedef struct packed {
        t_op                    op;
        logic [SLOT_W-1:0]      slot;
        logic [COUNT_W-1:0]     count;
        logic [ELAPSED_W-1:0]   elapsed;
    } t_cmd_beat;

    // directed row: a beat, plus the summary where it is obvious by eye
    typedef struct packed {
        t_cmd_beat              beat;
        logic                   typed;
        logic [DUE_W-1:0]       due;
        logic                   due_ok;
    } t_stim_row;

    localparam int N_ROWS = 22;

    // rows marked typed carry the summary they must produce; the rest go
    // through the table model
    t_stim_row directed_rows [N_ROWS] = '{
        // empty table after reset: no deadline
        '{'{OP_TICK,   6'd0,  32'd0,          31'd0},          1'b1, 31'd0, 1'b0},
        // freshly enrolled slot is inactive
        '{'{OP_INSERT, 6'd0,  32'd0,          31'd0},          1'b1, 31'd0, 1'b0},
        // zero count is forced up to one
        '{'{OP_PRIME,  6'd0,  32'd0,          31'd0},          1'b1, 31'd1, 1'b1},
        '{'{OP_INSERT, 6'd15, 32'd0,          31'd0},          1'b1, 31'd1, 1'b1},
        // most negative count: magnitude in microseconds
        '{'{OP_PRIME,  6'd15, 32'h8000_0000,  31'd0},          1'b1, 31'd1, 1'b1},
        // slot indexes past the table do nothing
        '{'{OP_PRIME,  6'd63, 32'd5,          31'd0},          1'b1, 31'd1, 1'b1},
        '{'{OP_INSERT, 6'd16, 32'd0,          31'd0},          1'b1, 31'd1, 1'b1},
        // prime of a slot that is not enrolled has no visible effect
        '{'{OP_PRIME,  6'd3,  32'd7,          31'd0},          1'b1, 31'd1, 1'b1},
        '{'{OP_REMOVE, 6'd40, 32'd0,          31'd0},          1'b1, 31'd1, 1'b1},
        // slot 0 runs out, slot 15 keeps counting
        '{'{OP_TICK,   6'd0,  32'd0,          31'd1},          1'b0, 31'd0, 1'b0},
        // fired slot is skipped by later ticks
        '{'{OP_TICK,   6'd0,  32'd0,          31'd0},          1'b0, 31'd0, 1'b0},
        // at the microsecond limit the value stays milliseconds, then clamps
        '{'{OP_PRIME,  6'd0,  -32'sd30,       31'd0},          1'b1, 31'd1, 1'b1},
        // just past the limit: under one millisecond, clamps to one
        '{'{OP_PRIME,  6'd0,  -32'sd31,       31'd0},          1'b1, 31'd1, 1'b1},
        '{'{OP_PRIME,  6'd0,  -32'sd1000000,  31'd0},          1'b0, 31'd0, 1'b0},
        '{'{OP_INSERT, 6'd5,  32'd0,          31'd0},          1'b0, 31'd0, 1'b0},
        // largest count counts down but is no deadline for the summary
        '{'{OP_PRIME,  6'd5,  32'h7FFF_FFFF,  31'd0},          1'b0, 31'd0, 1'b0},
        // insert of an enrolled slot makes it inactive again
        '{'{OP_INSERT, 6'd15, 32'd0,          31'd0},          1'b0, 31'd0, 1'b0},
        '{'{OP_PRIME,  6'd15, 32'd1,          31'd0},          1'b0, 31'd0, 1'b0},
        // largest elapsed time fires every active slot
        '{'{OP_TICK,   6'd0,  32'd0,          31'h7FFF_FFFF},  1'b0, 31'd0, 1'b0},
        '{'{OP_REMOVE, 6'd0,  32'd0,          31'd0},          1'b0, 31'd0, 1'b0},
        // remove of a slot that is not enrolled
        '{'{OP_REMOVE, 6'd0,  32'd0,          31'd0},          1'b0, 31'd0, 1'b0},
        '{'{OP_PRIME,  6'd0,  32'd12,         31'd0},          1'b0, 31'd0, 1'b0}
    };

    logic i_clk;
    logic i_rst_n;

    msct_cmd_if cmd_ch ();
    msct_res_if res_ch ();

    multi_slot_countdown_timer_top u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd_ch (cmd_ch),
        .o_res_ch (res_ch)
    );

    // bench copy of the slot table
    logic                       slot_enrolled [SLOTS];
    logic signed [COUNT_W-1:0]  slot_count    [SLOTS];

    // beats the table owes us, oldest first
    t_result pending_results [$];

    int unsigned send_idle_pct;
    int unsigned sink_stall_pct;
    int          fail_count;
    int          report_count;

    // ------------------------------------------------------------------------
    // clock
    // ------------------------------------------------------------------------
    initial i_clk = 1'b0;
    always #HALF_PERIOD i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // hard limit on the run: 17 beats per item, each held by long sink stalls,
    // across some 210 items comes to well under a tenth of this
    // ------------------------------------------------------------------------
    initial begin
        #10_000_000;
        $display("tb: FAIL");
        $finish;
    end

    // ------------------------------------------------------------------------
    // table model: applies one accepted command to the bench copy of the
    // table and queues the beats it causes; with_results low only updates
    // state, for rows whose summary is typed in
    // ------------------------------------------------------------------------
    function automatic void apply_timer_cmd(input t_cmd_beat b, input bit with_results);
        longint  ms;
        longint  left;
        logic signed [COUNT_W-1:0] soonest;
        t_result r;
        soonest = COUNT_W'(NO_DEADLINE);
        case (b.op)
            OP_INSERT: begin
                if (b.slot < SLOTS) begin
                    slot_enrolled[b.slot] = 1'b1;
                    slot_count[b.slot]    = INACTIVE;
                end
            end
            OP_REMOVE: begin
                if (b.slot < SLOTS) slot_enrolled[b.slot] = 1'b0;
            end
            OP_PRIME: begin
                // below the limit the count is microseconds, rounded down
                ms = longint'($signed(b.count));
                if (ms < longint'(MICRO_LIMIT)) ms = (-ms) / MICRO_DIV;
                if (ms <= 0) ms = 1;
                if (b.slot < SLOTS) slot_count[b.slot] = COUNT_W'(ms);
            end
            OP_TICK: begin
                // ascending slot order, only active enrolled slots count down
                for (int i = 0; i < SLOTS; i++) begin
                    if (slot_enrolled[i] && slot_count[i] > 0) begin
                        left = longint'(slot_count[i]) - longint'(b.elapsed);
                        slot_count[i] = COUNT_W'(left);
                        if (left <= 0 && with_results) begin
                            r = '{KIND_FIRED, SLOT_W'(i), '0, 1'b0, 1'b0};
                            pending_results.push_back(r);
                        end
                    end
                end
            end
            default: ;
        endcase

        // summary: least positive count; a count equal to the all-ones deadline means none
        for (int i = 0; i < SLOTS; i++) begin
            if (slot_enrolled[i] && slot_count[i] > 0 && slot_count[i] < soonest)
                soonest = slot_count[i];
        end
        if (with_results) begin
            if (soonest < COUNT_W'(NO_DEADLINE))
                r = '{KIND_SUMMARY, '0, DUE_W'(soonest), 1'b1, 1'b1};
            else
                r = '{KIND_SUMMARY, '0, '0, 1'b0, 1'b1};
            pending_results.push_back(r);
        end
    endfunction

    // ------------------------------------------------------------------------
    // random command beat: mostly well-formed traffic on real slots with
    // short counts and short ticks so timers actually fire, plus some noise
    // across the full field ranges
    // ------------------------------------------------------------------------
    function automatic t_cmd_beat random_cmd();
        t_cmd_beat   b;
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 20)      b.op = OP_INSERT;
        else if (roll < 30) b.op = OP_REMOVE;
        else if (roll < 65) b.op = OP_PRIME;
        else                b.op = OP_TICK;

        // one in ten beats may address a slot past the table
        if ($urandom_range(0, 9) == 0) b.slot = SLOT_W'($urandom_range(0, 63));
        else                           b.slot = SLOT_W'($urandom_range(0, SLOTS - 1));

        roll = $urandom_range(0, 99);
        if (roll < 60)      b.count = COUNT_W'($urandom_range(1, 50));
        else if (roll < 75) b.count = -COUNT_W'($urandom_range(31, 60000));
        else if (roll < 85) b.count = -COUNT_W'($urandom_range(0, 30));
        else                b.count = COUNT_W'($urandom());

        if ($urandom_range(0, 9) == 0) b.elapsed = ELAPSED_W'($urandom());
        else                           b.elapsed = ELAPSED_W'($urandom_range(0, 20));
        return b;
    endfunction

    // ------------------------------------------------------------------------
    // command driver: random idle cycles, then hold the beat until ready;
    // valid is left high on acceptance so back-to-back beats never drop it
    // ------------------------------------------------------------------------
    task automatic send_cmd(input t_cmd_beat b, input bit with_results);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            cmd_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        cmd_ch.valid   <= 1'b1;
        cmd_ch.cmd     <= b.op;
        cmd_ch.slot    <= b.slot;
        cmd_ch.count   <= b.count;
        cmd_ch.elapsed <= b.elapsed;
        @(posedge i_clk);
        while (!cmd_ch.ready) @(posedge i_clk);
        // beat taken at this edge
        apply_timer_cmd(b, with_results);
    endtask

    // pause the command side until the table has paid out everything
    task automatic drain_results();
        cmd_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------------
    // result sink: random stalls per the current phase
    // ------------------------------------------------------------------------
    initial res_ch.ready = 1'b0;
    always @(posedge i_clk) begin
        res_ch.ready <= ($urandom_range(0, 99) >= sink_stall_pct);
    end

    // ------------------------------------------------------------------------
    // result checker: each accepted beat against the oldest expectation
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            if (pending_results.size() == 0) begin
                fail_count++;
                if (report_count < MAX_REPORTS) begin
                    report_count++;
                    $display("tb: unexpected beat kind=%0d slot=%0d due=%0d ok=%0d last=%0d",
                             res_ch.kind, res_ch.fired_slot, res_ch.next_due,
                             res_ch.due_valid, res_ch.last);
                end
            end else begin
                want = pending_results.pop_front();
                if (res_ch.kind       !== want.kind       ||
                    res_ch.fired_slot !== want.fired_slot ||
                    res_ch.next_due   !== want.next_due   ||
                    res_ch.due_valid  !== want.due_valid  ||
                    res_ch.last       !== want.last) begin
                    fail_count++;
                    if (report_count < MAX_REPORTS) begin
                        report_count++;
                        $display("tb: mismatch at %0t exp kind=%0d slot=%0d due=%0d ok=%0d last=%0d",
                                 $realtime, want.kind, want.fired_slot, want.next_due,
                                 want.due_valid, want.last);
                        $display("tb:                 got kind=%0d slot=%0d due=%0d ok=%0d last=%0d",
                                 res_ch.kind, res_ch.fired_slot, res_ch.next_due,
                                 res_ch.due_valid, res_ch.last);
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial begin
        t_result typed_sum;

        fail_count     = 0;
        report_count   = 0;
        send_idle_pct  = 0;
        sink_stall_pct = 0;
        for (int i = 0; i < SLOTS; i++) begin
            slot_enrolled[i] = 1'b0;
            slot_count[i]    = '0;
        end

        i_rst_n        <= 1'b0;
        cmd_ch.valid   <= 1'b0;
        cmd_ch.cmd     <= OP_INSERT;
        cmd_ch.slot    <= '0;
        cmd_ch.count   <= '0;
        cmd_ch.elapsed <= '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table, full throughput on both sides
        for (int n = 0; n < N_ROWS; n++) begin
            if (directed_rows[n].typed) begin
                send_cmd(directed_rows[n].beat, 1'b0);
                typed_sum = '{KIND_SUMMARY, '0, directed_rows[n].due,
                              directed_rows[n].due_ok, 1'b1};
                pending_results.push_back(typed_sum);
            end else begin
                send_cmd(directed_rows[n].beat, 1'b1);
            end
        end

        // random phases: free flow, idle sender, stalling sink, both
        for (int phase = 0; phase < 4; phase++) begin
            // sender holds off until every owed beat has come out
            drain_results();
            case (phase)
                0: begin send_idle_pct = 0;  sink_stall_pct = 0;  end
                1: begin send_idle_pct = 68; sink_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  sink_stall_pct = 68; end
                default: begin send_idle_pct = 36; sink_stall_pct = 36; end
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++) send_cmd(random_cmd(), 1'b1);
        end

        // let the table finish, then watch for stray beats
        drain_results();
        sink_stall_pct = 0;
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0 && pending_results.size() == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end

endmodule
